FILE: rtl/core/icp_pkg.sv
// shared types, constants and helpers for the interrupt controller table parser
package icp_pkg;

    // record limits
    localparam int ICP_MAX_PROC = 64;
    localparam int ICP_MAX_IOC  = 16;
    localparam int ICP_CPU_CNT_W = $clog2(ICP_MAX_PROC + 1);
    localparam int ICP_IOC_CNT_W = $clog2(ICP_MAX_IOC + 1);

    // table layout
    localparam logic [31:0] ICP_HEADER_BYTES = 32'd44;
    localparam logic [7:0]  ICP_ENTRY_CPU    = 8'd0;
    localparam logic [7:0]  ICP_ENTRY_IOC    = 8'd1;

    // record kinds
    localparam logic [1:0] ICP_KIND_CPU = 2'd0;
    localparam logic [1:0] ICP_KIND_IOC = 2'd1;
    localparam logic [1:0] ICP_KIND_END = 2'd2;

    // end record status codes
    localparam logic [2:0] ICP_ST_OK        = 3'd0;
    localparam logic [2:0] ICP_ST_BAD_SIG   = 3'd1;
    localparam logic [2:0] ICP_ST_CHECKSUM  = 3'd2;
    localparam logic [2:0] ICP_ST_MALFORMED = 3'd3;
    localparam logic [2:0] ICP_ST_LENGTH    = 3'd4;

    // output queue
    localparam int ICP_Q_DEPTH = 4;
    localparam int ICP_Q_PTR_W = $clog2(ICP_Q_DEPTH);
    localparam int ICP_Q_CNT_W = $clog2(ICP_Q_DEPTH + 1);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } icp_in_t;

    typedef struct packed {
        logic [1:0]  record_kind;
        logic [5:0]  slot_index;
        logic [7:0]  apic_id;
        logic        boot_cpu;
        logic        usable;
        logic [31:0] ioapic_address;
        logic [31:0] local_apic_address;
        logic [6:0]  cpu_count;
        logic [4:0]  ioapic_count;
        logic [2:0]  status;
        logic        last_result;
    } icp_out_t;

    // up to two beats produced by one table byte, first one in res0
    typedef struct packed {
        logic [1:0] cnt;
        icp_out_t   res0;
        icp_out_t   res1;
    } icp_push_t;

    // signature "APIC"
    function automatic logic [7:0] icp_sig_byte(input logic [1:0] idx);
        logic [7:0] val;
        unique case (idx)
            2'd0: val = 8'h41;
            2'd1: val = 8'h50;
            2'd2: val = 8'h49;
            default: val = 8'h43;
        endcase
        return val;
    endfunction

endpackage

FILE: rtl/core/icp_parser.sv
// input register and per-byte table parsing logic
module icp_parser
    import icp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_ready,
    input  icp_in_t   item,
    input  logic      space_ok,
    output icp_push_t push
);

    localparam logic [7:0] CPU_ID_POS    = 8'd3;
    localparam logic [7:0] CPU_FLAGS_POS = 8'd4;
    localparam logic [7:0] IOC_ID_POS    = 8'd2;
    localparam logic [7:0] IOC_ADDR_POS  = 8'd4;
    localparam logic [7:0] IOC_LAST_POS  = 8'd7;

    // input register
    logic    vld_reg;
    icp_in_t in_reg;
    logic    adv;

    assign adv        = vld_reg && space_ok;
    assign item_ready = !vld_reg || adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            vld_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            in_reg <= item;
        end
    end

    // parser state
    logic [31:0]              offset_reg, offset_next;
    logic [31:0]              tlen_reg, tlen_next;
    logic [7:0]               sum_reg, sum_next;
    logic                     sig_ok_reg, sig_ok_next;
    logic [31:0]              laddr_reg, laddr_next;
    logic [7:0]               etype_reg, etype_next;
    logic [7:0]               elen_reg, elen_next;
    logic [7:0]               epos_reg, epos_next;
    logic [7:0]               eid_reg, eid_next;
    logic [31:0]              eword_reg, eword_next;
    logic [ICP_CPU_CNT_W-1:0] ncpu_reg, ncpu_next;
    logic [ICP_IOC_CNT_W-1:0] nioc_reg, nioc_next;
    logic                     malf_reg, malf_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            tlen_reg   <= '0;
            sum_reg    <= '0;
            sig_ok_reg <= 1'b1;
            laddr_reg  <= '0;
            etype_reg  <= '0;
            elen_reg   <= '0;
            epos_reg   <= '0;
            eid_reg    <= '0;
            eword_reg  <= '0;
            ncpu_reg   <= '0;
            nioc_reg   <= '0;
            malf_reg   <= 1'b0;
        end
        else if (adv)
        begin
            offset_reg <= offset_next;
            tlen_reg   <= tlen_next;
            sum_reg    <= sum_next;
            sig_ok_reg <= sig_ok_next;
            laddr_reg  <= laddr_next;
            etype_reg  <= etype_next;
            elen_reg   <= elen_next;
            epos_reg   <= epos_next;
            eid_reg    <= eid_next;
            eword_reg  <= eword_next;
            ncpu_reg   <= ncpu_next;
            nioc_reg   <= nioc_next;
            malf_reg   <= malf_next;
        end
    end

    logic [7:0]               b;
    logic                     rec_vld;
    icp_out_t                 rec;
    icp_out_t                 fin;
    logic [32:0]              count;
    logic [8:0]               pos_inc;
    logic [7:0]               sum_new;
    logic                     sig_new;
    logic [31:0]              tlen_new;
    logic [31:0]              laddr_new;
    logic [ICP_CPU_CNT_W-1:0] ncpu_new;
    logic [ICP_IOC_CNT_W-1:0] nioc_new;
    logic                     malf_new;
    logic [2:0]               st;

    assign b       = in_reg.data_byte;
    assign count   = {1'b0, offset_reg} + 33'd1;
    assign pos_inc = {1'b0, epos_reg} + 9'd1;

    // header fields, checksum and signature
    always_comb
    begin
        sum_new   = sum_reg + b;
        sig_new   = sig_ok_reg;
        tlen_new  = tlen_reg;
        laddr_new = laddr_reg;
        if (offset_reg < 32'd4 && b != icp_sig_byte(offset_reg[1:0]))
        begin
            sig_new = 1'b0;
        end
        if (offset_reg >= 32'd4 && offset_reg < 32'd8)
        begin
            tlen_new[8*(offset_reg[1:0]) +: 8] = b;
        end
        if (offset_reg >= 32'd36 && offset_reg < 32'd40)
        begin
            laddr_new[8*(offset_reg[1:0]) +: 8] = b;
        end
    end

    // entry walk
    always_comb
    begin
        etype_next = etype_reg;
        elen_next  = elen_reg;
        epos_next  = epos_reg;
        eid_next   = eid_reg;
        eword_next = eword_reg;
        ncpu_new   = ncpu_reg;
        nioc_new   = nioc_reg;
        malf_new   = malf_reg;
        rec_vld    = 1'b0;
        rec        = '0;
        if (epos_reg == 8'd0)
        begin
            // waiting for an entry start
            if (!malf_reg && offset_reg >= ICP_HEADER_BYTES && offset_reg < tlen_reg)
            begin
                etype_next = b;
                eid_next   = '0;
                eword_next = '0;
                epos_next  = 8'd1;
            end
        end
        else if (epos_reg == 8'd1)
        begin
            // entry length byte
            elen_next = b;
            if (b < 8'd2)
            begin
                malf_new  = 1'b1;
                epos_next = 8'd0;
            end
            else
            begin
                epos_next = (b > 8'd2) ? 8'd2 : 8'd0;
            end
        end
        else
        begin
            if (etype_reg == ICP_ENTRY_CPU)
            begin
                if (epos_reg == CPU_ID_POS)
                begin
                    eid_next = b;
                end
                if (epos_reg == CPU_FLAGS_POS && b[1:0] != 2'b00
                    && ncpu_reg < ICP_CPU_CNT_W'(ICP_MAX_PROC))
                begin
                    rec_vld          = 1'b1;
                    rec.record_kind  = ICP_KIND_CPU;
                    rec.slot_index   = 6'(ncpu_reg);
                    rec.apic_id      = eid_reg;
                    rec.boot_cpu     = b[0];
                    rec.usable       = 1'b1;
                    ncpu_new         = ncpu_reg + 1'b1;
                end
            end
            else if (etype_reg == ICP_ENTRY_IOC)
            begin
                if (epos_reg == IOC_ID_POS)
                begin
                    eid_next = b;
                end
                if (epos_reg >= IOC_ADDR_POS && epos_reg <= IOC_LAST_POS)
                begin
                    eword_next[8*(epos_reg[1:0]) +: 8] = eword_reg[8*(epos_reg[1:0]) +: 8] | b;
                end
                if (epos_reg == IOC_LAST_POS && nioc_reg < ICP_IOC_CNT_W'(ICP_MAX_IOC))
                begin
                    rec_vld            = 1'b1;
                    rec.record_kind    = ICP_KIND_IOC;
                    rec.slot_index     = 6'(nioc_reg);
                    rec.apic_id        = eid_reg;
                    rec.ioapic_address = eword_next;
                    nioc_new           = nioc_reg + 1'b1;
                end
            end
            if (pos_inc >= {1'b0, elen_reg})
            begin
                epos_next = 8'd0;
            end
            else
            begin
                epos_next = pos_inc[7:0];
            end
        end
        // a last byte ends any entry in progress
        if (in_reg.last_byte)
        begin
            etype_next = '0;
            elen_next  = '0;
            epos_next  = '0;
            eid_next   = '0;
            eword_next = '0;
        end
    end

    // end record status
    always_comb
    begin
        priority if (!sig_new || count < 33'd4)
        begin
            st = ICP_ST_BAD_SIG;
        end
        else if (sum_new != 8'd0)
        begin
            st = ICP_ST_CHECKSUM;
        end
        else if (malf_new)
        begin
            st = ICP_ST_MALFORMED;
        end
        else if (count != {1'b0, tlen_new} || count < {1'b0, ICP_HEADER_BYTES})
        begin
            st = ICP_ST_LENGTH;
        end
        else
        begin
            st = ICP_ST_OK;
        end
    end

    always_comb
    begin
        fin                    = '0;
        fin.record_kind        = ICP_KIND_END;
        fin.local_apic_address = laddr_new;
        fin.cpu_count          = 7'(ncpu_new);
        fin.ioapic_count       = 5'(nioc_new);
        fin.status             = st;
        fin.last_result        = 1'b1;
    end

    // next state: a last byte returns everything to reset values
    always_comb
    begin
        offset_next = (offset_reg != 32'hFFFF_FFFF) ? offset_reg + 32'd1 : offset_reg;
        tlen_next   = tlen_new;
        sum_next    = sum_new;
        sig_ok_next = sig_new;
        laddr_next  = laddr_new;
        ncpu_next   = ncpu_new;
        nioc_next   = nioc_new;
        malf_next   = malf_new;
        if (in_reg.last_byte)
        begin
            offset_next = '0;
            tlen_next   = '0;
            sum_next    = '0;
            sig_ok_next = 1'b1;
            laddr_next  = '0;
            ncpu_next   = '0;
            nioc_next   = '0;
            malf_next   = 1'b0;
        end
    end

    // beats handed to the output queue
    always_comb
    begin
        push      = '0;
        push.res0 = rec;
        push.res1 = fin;
        if (adv)
        begin
            if (in_reg.last_byte)
            begin
                if (rec_vld)
                begin
                    push.cnt = 2'd2;
                end
                else
                begin
                    push.cnt  = 2'd1;
                    push.res0 = fin;
                end
            end
            else if (rec_vld)
            begin
                push.cnt              = 2'd1;
                push.res0.last_result = 1'b1;
            end
        end
    end

endmodule

FILE: rtl/core/icp_out_queue.sv
// small output queue taking up to two beats per cycle and giving one per cycle while result_ready is high
module icp_out_queue
    import icp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  icp_push_t push,
    output logic      space_ok,
    output logic      result_valid,
    input  logic      result_ready,
    output icp_out_t  result
);

    icp_out_t               q_reg [ICP_Q_DEPTH];
    logic [ICP_Q_PTR_W-1:0] wr_reg, wr_next;
    logic [ICP_Q_PTR_W-1:0] rd_reg, rd_next;
    logic [ICP_Q_CNT_W-1:0] cnt_reg, cnt_next;
    logic [ICP_Q_PTR_W-1:0] wr_second;
    logic                   pop;

    assign result_valid = (cnt_reg != '0);
    assign result       = q_reg[rd_reg];
    assign pop          = result_valid && result_ready;
    // room for two more beats
    assign space_ok     = (cnt_reg <= ICP_Q_CNT_W'(ICP_Q_DEPTH - 2));
    assign wr_second    = wr_reg + 1'b1;

    // pointers and fill count
    always_comb
    begin
        wr_next  = wr_reg + ICP_Q_PTR_W'(push.cnt);
        rd_next  = pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + ICP_Q_CNT_W'(push.cnt) - ICP_Q_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
        begin
            q_reg[wr_reg] <= push.res0;
        end
        if (push.cnt == 2'd2)
        begin
            q_reg[wr_second] <= push.res1;
        end
    end

endmodule

FILE: rtl/core/interrupt_controller_table_parser_core.sv
// top level of the interrupt controller table parser
// Takes one table byte per cycle, first signature byte first, while the
// output queue has room: a byte sits in the input register, where the
// checksum, header capture and entry walk are done, and its beats go to a
// four-deep output queue. A byte yields at most two beats (a processor or I/O
// controller record, then the end record on the last byte); item_ready drops
// while a byte waits and the queue holds more than two beats, so a stalled
// result side holds back the input after a few bytes. Records are issued before
// the checksum is known: discard them when the end record's status is not zero.
module interrupt_controller_table_parser_core
    import icp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_ready,
    input  icp_in_t  item,
    output logic     result_valid,
    input  logic     result_ready,
    output icp_out_t result
);

    icp_push_t push;
    logic      space_ok;

    // byte parser
    icp_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .space_ok   (space_ok),
        .push       (push)
    );

    // result queue
    icp_out_queue u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .space_ok     (space_ok),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
